// ===== src/fcs_pkg.sv =====
// Package of the five-stage CPU subset step block: command and hazard codes,
// the request and response word layouts and fixed arithmetic constants.
// No dependencies; compile first.
`default_nettype none

package fcs_pkg;

   typedef logic [2:0] command_type;

   localparam command_type CMD_ADD = 3'd0;
   localparam command_type CMD_SUB = 3'd1;
   localparam command_type CMD_LW  = 3'd2;
   localparam command_type CMD_SW  = 3'd3;
   localparam command_type CMD_BEQ = 3'd4;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_NONE  = 2'd0;
   localparam kind_type KIND_LOAD  = 2'd1;
   localparam kind_type KIND_ALU   = 2'd2;
   localparam kind_type KIND_OTHER = 2'd3;

   // Magnitude width of the immediate and the shift of the reciprocal multiply.
   localparam int MAG_W       = 17;
   localparam int RECIP_SHIFT = 34;

   typedef struct packed {
      command_type        command;
      logic [4:0]         dest_reg;
      logic [4:0]         src_reg;
      logic [4:0]         tgt_reg;
      logic signed [15:0] immediate;
   } req_word_type;

   typedef struct packed {
      logic [1:0]         stall_cycles;
      logic               branch_taken;
      logic [9:0]         next_pc;
      logic               reg_dst;
      logic               alu_src;
      logic               is_branch;
      logic               mem_read;
      logic               mem_write;
      logic               reg_write;
      logic               mem_to_reg;
      logic signed [31:0] result_value;
   } rsp_word_type;

endpackage

`default_nettype wire

// ===== src/fcs_chan_if.sv =====
// Valid/ready channel interfaces for the request and response words.
// Depends on fcs_pkg for the word layouts.
`default_nettype none

interface fcs_req_if;
   import fcs_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface fcs_rsp_if;
   import fcs_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/five_stage_cpu_subset_step.sv =====
// Top level of the five-stage CPU subset step block (add, sub, lw, sw, beq).
// Depends on fcs_pkg and on the fcs_req_if and fcs_rsp_if channel interfaces.
`default_nettype none

// The block takes one decoded instruction word per clock while it is not stalled or clearing,
// and returns one response word per instruction, in order; a response word passes through
// the input, second-stage, execute and writeback registers. The rate of one word per clock
// is set by the execute stage, where register values are forwarded from the two previous
// writes and the load address is formed for the data memory read. After reset the block
// sets register zero to zero and every other register and data memory word to one, with
// req_chan.ready low. A response word that is not taken stalls the pipeline; a request word
// is still taken into the input register only while that register is empty.
module five_stage_cpu_subset_step #(
   parameter int REGISTER_COUNT = 32,
   parameter int MEMORY_WORDS   = 32,
   parameter int PROGRAM_DEPTH  = 1024
) (
   input  logic       clock,
   input  logic       reset,
   fcs_req_if.sink    req_chan,
   fcs_rsp_if.source  rsp_chan
);
   import fcs_pkg::*;

   localparam int RW        = $clog2(REGISTER_COUNT);
   localparam int AW        = $clog2(MEMORY_WORDS);
   localparam int AW1       = AW + 1;
   localparam int PW        = $clog2(PROGRAM_DEPTH);
   localparam int PW1       = PW + 1;
   localparam int PXW       = (PW > 10) ? PW : 10;
   localparam int CLR_COUNT = (REGISTER_COUNT > MEMORY_WORDS) ? REGISTER_COUNT : MEMORY_WORDS;
   localparam int CW        = $clog2(CLR_COUNT + 1);
   localparam int PROD_W    = RECIP_SHIFT + MAG_W;
   localparam int QPROD_W   = MAG_W + 17;

   localparam longint unsigned RECIP_MEM =
      ((64'd1 << RECIP_SHIFT) + 64'(MEMORY_WORDS) - 64'd1) / 64'(MEMORY_WORDS);
   localparam longint unsigned RECIP_PC =
      ((64'd1 << RECIP_SHIFT) + 64'(PROGRAM_DEPTH) - 64'd1) / 64'(PROGRAM_DEPTH);
   localparam longint unsigned WRAP_MEM = (64'd1 << 32) % 64'(MEMORY_WORDS);

   // Each stored word carries its signed value modulo MEMORY_WORDS.
   typedef struct packed {
      logic [31:0]   val;
      logic [AW-1:0] res;
   } entry_type;

   typedef struct packed {
      command_type        cmd;
      logic [RW-1:0]      rd;
      logic [RW-1:0]      rs;
      logic [RW-1:0]      rt;
      logic               neg;
      logic [MAG_W-1:0]   qmag;
      logic [MAG_W-1:0]   qquot;
      logic [MAG_W-1:0]   imag;
      logic [MAG_W-1:0]   iquot;
   } s1_stage_type;

   typedef struct packed {
      command_type   cmd;
      logic [RW-1:0] rd;
      logic [RW-1:0] rs;
      logic [RW-1:0] rt;
      logic [AW-1:0] qres;
      logic [PW-1:0] ires;
   } e_stage_type;

   function automatic logic [RW-1:0] reg_idx(input logic [4:0] f);
      logic [5:0] r;
      r = {1'b0, f};
      for (int i = 0; i < 4; i++) begin
         if (r >= 6'(REGISTER_COUNT)) begin
            r = r - 6'(REGISTER_COUNT);
         end
      end
      return RW'(r);
   endfunction

   function automatic logic [AW-1:0] mem_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= AW1'(MEMORY_WORDS)) begin
         s = s - AW1'(MEMORY_WORDS);
      end
      return s[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] mem_sub(input logic [AW-1:0] a, input logic [AW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} - {1'b0, b};
      if (s[AW]) begin
         s = s + AW1'(MEMORY_WORDS);
      end
      return s[AW-1:0];
   endfunction

   function automatic logic [PW-1:0] pc_add(input logic [PW-1:0] a, input logic [PW-1:0] b);
      logic [PW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= PW1'(PROGRAM_DEPTH)) begin
         s = s - PW1'(PROGRAM_DEPTH);
      end
      return s[PW-1:0];
   endfunction

   // Clearing pass.
   logic          clear_ff;
   logic [CW-1:0] clr_cnt_ff;

   // Pipeline registers.
   logic          en;
   logic          s0_valid_ff;
   req_word_type  s0_word_ff;
   logic          s1_valid_ff;
   s1_stage_type  s1_ff;
   s1_stage_type  s1_in;
   logic          e_valid_ff;
   e_stage_type   e_ff;
   e_stage_type   e_in;
   logic          w_valid_ff;
   rsp_word_type  w_rsp_ff;
   rsp_word_type  w_rsp_in;
   logic          w_is_load_ff;
   logic          w_is_load_in;
   logic          w_rw_ff;
   logic          w_rw_in;
   logic [RW-1:0] w_dest_ff;
   entry_type     w_ent_ff;
   entry_type     w_ent_in;
   entry_type     w_data;
   logic          x_valid_ff;
   logic [RW-1:0] x_dest_ff;
   entry_type     x_ent_ff;

   // Architectural state.
   logic [PW-1:0] pc_ff;
   logic [PW-1:0] pc_in;
   kind_type      prev_kind_ff;
   kind_type      prev_kind_in;
   logic [RW-1:0] prev_dest_ff;
   logic [RW-1:0] prev_dest_in;

   // Memories.
   entry_type     rf_mem [REGISTER_COUNT];
   entry_type     dm_mem [MEMORY_WORDS];
   entry_type     rs_data_ff;
   entry_type     rt_data_ff;
   entry_type     mem_data_ff;
   logic          rf_we;
   logic [RW-1:0] rf_waddr;
   entry_type     rf_wdata;
   logic          dm_we;
   logic [AW-1:0] dm_waddr;
   entry_type     dm_wdata;

   // Execute stage signals.
   logic          e_fire;
   entry_type     a_ent;
   entry_type     b_ent;
   logic [31:0]   sum;
   logic [31:0]   diff;
   logic          pos_ovf;
   logic          neg_ovf;
   logic [AW-1:0] base_res;
   logic [AW-1:0] alu_res;
   logic [AW-1:0] e_addr;
   logic          taken;
   logic [PW-1:0] pc_inc;
   logic [PXW-1:0] pc_ext;
   logic          reads_rs;
   logic          reads_rt;
   logic          dep;
   logic [1:0]    stall;

   // Input stage: register indices and immediate magnitudes with their quotients.
   logic [MAG_W-1:0]  imm_mag;
   logic [MAG_W-1:0]  q_mag;
   logic [PROD_W-1:0] q_prod;
   logic [PROD_W-1:0] i_prod;

   assign en             = !(w_valid_ff && !rsp_chan.ready);
   assign req_chan.ready = !clear_ff && (en || !s0_valid_ff);
   assign e_fire         = en && e_valid_ff;
   assign w_data         = w_is_load_ff ? mem_data_ff : w_ent_ff;

   always_comb begin
      imm_mag      = s0_word_ff.immediate[15] ?
                     MAG_W'(-{s0_word_ff.immediate[15], s0_word_ff.immediate}) :
                     MAG_W'({s0_word_ff.immediate[15], s0_word_ff.immediate});
      q_mag        = imm_mag >> 2;
      q_prod       = PROD_W'(q_mag) * PROD_W'(RECIP_MEM);
      i_prod       = PROD_W'(imm_mag) * PROD_W'(RECIP_PC);
      s1_in.cmd    = s0_word_ff.command;
      s1_in.rd     = reg_idx(s0_word_ff.dest_reg);
      s1_in.rs     = reg_idx(s0_word_ff.src_reg);
      s1_in.rt     = reg_idx(s0_word_ff.tgt_reg);
      s1_in.neg    = s0_word_ff.immediate[15];
      s1_in.qmag   = q_mag;
      s1_in.qquot  = q_prod[RECIP_SHIFT +: MAG_W];
      s1_in.imag   = imm_mag;
      s1_in.iquot  = i_prod[RECIP_SHIFT +: MAG_W];
   end

   // Second stage: exact remainders, then the signed residues of the offsets.
   logic [QPROD_W-1:0] q_back;
   logic [QPROD_W-1:0] i_back;
   logic [MAG_W-1:0]   q_rem;
   logic [MAG_W-1:0]   i_rem;

   always_comb begin
      q_back    = QPROD_W'(s1_ff.qquot) * QPROD_W'(MEMORY_WORDS);
      i_back    = QPROD_W'(s1_ff.iquot) * QPROD_W'(PROGRAM_DEPTH);
      q_rem     = s1_ff.qmag - q_back[MAG_W-1:0];
      i_rem     = s1_ff.imag - i_back[MAG_W-1:0];
      e_in.cmd  = s1_ff.cmd;
      e_in.rd   = s1_ff.rd;
      e_in.rs   = s1_ff.rs;
      e_in.rt   = s1_ff.rt;
      e_in.qres = (s1_ff.neg && q_rem != '0) ?
                  AW'(MAG_W'(MEMORY_WORDS) - q_rem) : AW'(q_rem);
      e_in.ires = (s1_ff.neg && i_rem != '0) ?
                  PW'(MAG_W'(PROGRAM_DEPTH) - i_rem) : PW'(i_rem);
   end

   // Execute stage: forwarding from the two previous writes, then the operation.
   always_comb begin
      a_ent = rs_data_ff;
      priority if (w_valid_ff && w_rw_ff && w_dest_ff == e_ff.rs) begin
         a_ent = w_data;
      end else if (x_valid_ff && x_dest_ff == e_ff.rs) begin
         a_ent = x_ent_ff;
      end else begin
         a_ent = rs_data_ff;
      end
      b_ent = rt_data_ff;
      priority if (w_valid_ff && w_rw_ff && w_dest_ff == e_ff.rt) begin
         b_ent = w_data;
      end else if (x_valid_ff && x_dest_ff == e_ff.rt) begin
         b_ent = x_ent_ff;
      end else begin
         b_ent = rt_data_ff;
      end
   end

   always_comb begin
      sum  = a_ent.val + b_ent.val;
      diff = a_ent.val - b_ent.val;
      if (e_ff.cmd == CMD_SUB) begin
         base_res = mem_sub(a_ent.res, b_ent.res);
         pos_ovf  = !a_ent.val[31] && b_ent.val[31] && diff[31];
         neg_ovf  = a_ent.val[31] && !b_ent.val[31] && !diff[31];
      end else begin
         base_res = mem_add(a_ent.res, b_ent.res);
         pos_ovf  = !a_ent.val[31] && !b_ent.val[31] && sum[31];
         neg_ovf  = a_ent.val[31] && b_ent.val[31] && !sum[31];
      end
      // A wrapped result differs from the true one by 2^32, so its residue shifts too.
      priority if (pos_ovf) begin
         alu_res = mem_sub(base_res, AW'(WRAP_MEM));
      end else if (neg_ovf) begin
         alu_res = mem_add(base_res, AW'(WRAP_MEM));
      end else begin
         alu_res = base_res;
      end
      e_addr = mem_add(a_ent.res, e_ff.qres);
      taken  = (e_ff.cmd == CMD_BEQ) && (a_ent.val == b_ent.val);
      pc_inc = (pc_ff == PW'(PROGRAM_DEPTH - 1)) ? '0 : pc_ff + PW'(1);
      pc_in  = taken ? pc_add(pc_inc, e_ff.ires) : pc_inc;
      pc_ext = PXW'(pc_in);
   end

   always_comb begin
      reads_rs = e_ff.cmd <= CMD_BEQ;
      reads_rt = e_ff.cmd == CMD_ADD || e_ff.cmd == CMD_SUB ||
                 e_ff.cmd == CMD_SW || e_ff.cmd == CMD_BEQ;
      dep      = prev_dest_ff != '0 &&
                 ((reads_rs && prev_dest_ff == e_ff.rs) ||
                  (reads_rt && prev_dest_ff == e_ff.rt));
      priority if (prev_kind_ff == KIND_LOAD && dep) begin
         stall = (e_ff.cmd == CMD_BEQ) ? 2'd2 : 2'd1;
      end else if (prev_kind_ff == KIND_ALU && dep && e_ff.cmd == CMD_BEQ) begin
         stall = 2'd1;
      end else begin
         stall = 2'd0;
      end
   end

   always_comb begin
      w_rsp_in              = '0;
      w_rsp_in.stall_cycles = stall;
      w_rsp_in.branch_taken = taken;
      w_rsp_in.next_pc      = pc_ext[9:0];
      w_ent_in              = '{val: a_ent.val, res: alu_res};
      w_is_load_in          = 1'b0;
      w_rw_in               = 1'b0;
      prev_kind_in          = KIND_OTHER;
      prev_dest_in          = '0;
      unique case (e_ff.cmd)
         CMD_ADD, CMD_SUB: begin
            w_ent_in.val          = (e_ff.cmd == CMD_ADD) ? sum : diff;
            w_rsp_in.reg_dst      = 1'b1;
            w_rsp_in.reg_write    = 1'b1;
            w_rsp_in.result_value = $signed(w_ent_in.val);
            w_rw_in               = e_ff.rd != '0;
            prev_kind_in          = KIND_ALU;
            prev_dest_in          = e_ff.rd;
         end
         CMD_LW: begin
            w_rsp_in.alu_src    = 1'b1;
            w_rsp_in.mem_read   = 1'b1;
            w_rsp_in.reg_write  = 1'b1;
            w_rsp_in.mem_to_reg = 1'b1;
            w_is_load_in        = 1'b1;
            w_rw_in             = e_ff.rt != '0;
            prev_kind_in        = KIND_LOAD;
            prev_dest_in        = e_ff.rt;
         end
         CMD_SW: begin
            w_rsp_in.alu_src      = 1'b1;
            w_rsp_in.mem_write    = 1'b1;
            w_rsp_in.result_value = $signed(b_ent.val);
         end
         CMD_BEQ: begin
            w_rsp_in.is_branch = 1'b1;
         end
         default: begin
            w_rsp_in.next_pc = pc_ext[9:0];
         end
      endcase
   end

   // Memory write ports: the clearing pass, then writeback and stores.
   always_comb begin
      if (clear_ff) begin
         rf_we    = clr_cnt_ff < CW'(REGISTER_COUNT);
         rf_waddr = clr_cnt_ff[RW-1:0];
         rf_wdata = (clr_cnt_ff == '0) ? entry_type'('0) :
                    entry_type'{val: 32'd1, res: AW'(1)};
         dm_we    = clr_cnt_ff < CW'(MEMORY_WORDS);
         dm_waddr = clr_cnt_ff[AW-1:0];
         dm_wdata = '{val: 32'd1, res: AW'(1)};
      end else begin
         rf_we    = en && w_valid_ff && w_rw_ff;
         rf_waddr = w_dest_ff;
         rf_wdata = w_data;
         dm_we    = e_fire && e_ff.cmd == CMD_SW;
         dm_waddr = e_addr;
         dm_wdata = b_ent;
      end
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         rf_mem[rf_waddr] <= rf_wdata;
      end
      if (en) begin
         rs_data_ff <= rf_mem[s1_ff.rs];
         rt_data_ff <= rf_mem[s1_ff.rt];
      end
   end

   always_ff @(posedge clock) begin
      if (dm_we) begin
         dm_mem[dm_waddr] <= dm_wdata;
      end
      if (e_fire && e_ff.cmd == CMD_LW) begin
         mem_data_ff <= dm_mem[e_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clr_cnt_ff   <= '0;
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         e_valid_ff   <= 1'b0;
         w_valid_ff   <= 1'b0;
         x_valid_ff   <= 1'b0;
         pc_ff        <= '0;
         prev_kind_ff <= KIND_NONE;
         prev_dest_ff <= '0;
      end else begin
         if (clear_ff) begin
            clr_cnt_ff <= clr_cnt_ff + CW'(1);
            if (clr_cnt_ff == CW'(CLR_COUNT - 1)) begin
               clear_ff <= 1'b0;
            end
         end
         if (req_chan.ready) begin
            s0_valid_ff <= req_chan.valid;
         end
         if (en) begin
            s1_valid_ff <= s0_valid_ff;
            e_valid_ff  <= s1_valid_ff;
            w_valid_ff  <= e_valid_ff;
         end
         if (en && w_valid_ff && w_rw_ff) begin
            x_valid_ff <= 1'b1;
         end
         if (e_fire) begin
            pc_ff        <= pc_in;
            prev_kind_ff <= prev_kind_in;
            prev_dest_ff <= prev_dest_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         s0_word_ff <= req_chan.data;
      end
      if (en) begin
         s1_ff        <= s1_in;
         e_ff         <= e_in;
         w_rsp_ff     <= w_rsp_in;
         w_ent_ff     <= w_ent_in;
         w_is_load_ff <= w_is_load_in;
         w_rw_ff      <= w_rw_in;
         w_dest_ff    <= w_is_load_in ? e_ff.rt : e_ff.rd;
      end
      if (en && w_valid_ff && w_rw_ff) begin
         x_dest_ff <= w_dest_ff;
         x_ent_ff  <= w_data;
      end
   end

   always_comb begin
      rsp_chan.data = w_rsp_ff;
      if (w_is_load_ff) begin
         rsp_chan.data.result_value = $signed(mem_data_ff.val);
      end
   end
   assign rsp_chan.valid = w_valid_ff;

   a_no_zero_write: assert property (@(posedge clock) disable iff (reset)
      rf_we && !clear_ff |-> rf_waddr != '0)
      else $error("register zero written by an instruction");

   a_load_addr_range: assert property (@(posedge clock) disable iff (reset)
      e_fire && (e_ff.cmd == CMD_LW || e_ff.cmd == CMD_SW) |-> int'(e_addr) < MEMORY_WORDS)
      else $error("data memory address out of range");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      int'(pc_ff) < PROGRAM_DEPTH)
      else $error("program counter out of range");

   a_two_stall_beq: assert property (@(posedge clock) disable iff (reset)
      w_valid_ff && w_rsp_ff.stall_cycles == 2'd2 |-> w_rsp_ff.is_branch)
      else $error("two-cycle stall on a non-branch");

   a_idle_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !s0_valid_ff && !e_valid_ff && !w_valid_ff)
      else $error("instruction in flight during clearing pass");

endmodule

`default_nettype wire
